### rtl/core/dmwc_pkg.sv
// ----------------------------------------------------------------------------
// dmwc_pkg
// Shared constants, types and helpers of the direct-mapped write-back cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dmwc_pkg;

  // Geometry
  localparam int INDEX_BITS     = 8;
  localparam int WORDS_PER_LINE = 16;
  localparam int MEM_WORDS      = 16384;

  localparam int ADDR_W      = 16;
  localparam int WORD_AW     = ADDR_W - 2;
  localparam int OFF_W       = $clog2(WORDS_PER_LINE);
  localparam int IDX_W       = INDEX_BITS;
  localparam int TAG_W       = WORD_AW - OFF_W - IDX_W;
  localparam int TAG_RAM_W   = TAG_W + 1;
  localparam int LINES       = 1 << INDEX_BITS;
  localparam int CACHE_WORDS = LINES * WORDS_PER_LINE;
  localparam int CACHE_AW    = IDX_W + OFF_W;
  localparam int MEM_AW      = $clog2(MEM_WORDS);
  localparam int BEAT_W      = OFF_W + 1;

  localparam int DATA_W = 32;
  localparam int TIME_W = 32;
  localparam int LAT_W  = 16;
  localparam int OP_W   = 2;

  // Stream packing
  localparam int IN_FIELDS_W  = OP_W + ADDR_W + DATA_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = DATA_W + 1 + 1 + TIME_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  // Operation codes
  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_RD   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_WR   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CACHE_RD = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CACHE_WR = 4'd3;

  // Latency reset values
  localparam logic [LAT_W-1:0] MEM_RD_RST   = 16'd100;
  localparam logic [LAT_W-1:0] MEM_WR_RST   = 16'd50;
  localparam logic [LAT_W-1:0] CACHE_RD_RST = 16'd1;
  localparam logic [LAT_W-1:0] CACHE_WR_RST = 16'd1;

  typedef struct packed {
    logic [LAT_W-1:0] mem_rd;
    logic [LAT_W-1:0] mem_wr;
    logic [LAT_W-1:0] cache_rd;
    logic [LAT_W-1:0] cache_wr;
  } lat_t;

  // Tag memory entry: dirty bit above the tag
  typedef struct packed {
    logic                 we;
    logic [IDX_W-1:0]     waddr;
    logic [TAG_RAM_W-1:0] wdata;
    logic                 re;
    logic [IDX_W-1:0]     raddr;
  } tag_req_t;

  typedef struct packed {
    logic                we;
    logic [CACHE_AW-1:0] waddr;
    logic [DATA_W-1:0]   wdata;
    logic                re;
    logic [CACHE_AW-1:0] raddr;
  } cache_req_t;

  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [MEM_AW-1:0] raddr;
  } mem_req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_WBACK,
    ST_FILL,
    ST_ACCESS,
    ST_FINISH
  } state_t;

  // Backing memory word of a line; the word index wraps at the memory size
  function automatic logic [MEM_AW-1:0] mem_addr(input logic [TAG_W-1:0] tag,
                                                 input logic [IDX_W-1:0] idx,
                                                 input logic [OFF_W-1:0] off);
    logic [WORD_AW-1:0] word;
    word     = {tag, idx, off};
    mem_addr = MEM_AW'(word);
  endfunction

endpackage

`default_nettype wire

### rtl/core/dmwc_ram.sv
// ----------------------------------------------------------------------------
// dmwc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmwc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and hold read data until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/dmwc_cfg.sv
// ----------------------------------------------------------------------------
// dmwc_cfg
// Latency registers of the time accounting, written over the config channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmwc_cfg
  import dmwc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [LAT_W-1:0]     cfg_data,
  output lat_t                      lat
);

  lat_t lat_r;
  lat_t lat_nxt;

  assign cfg_ready = 1'b1;
  assign lat       = lat_r;

  // Decode the register index; unknown indexes drop the write
  always_comb begin
    lat_nxt = lat_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MEM_RD:   lat_nxt.mem_rd   = cfg_data;
        CFG_MEM_WR:   lat_nxt.mem_wr   = cfg_data;
        CFG_CACHE_RD: lat_nxt.cache_rd = cfg_data;
        CFG_CACHE_WR: lat_nxt.cache_wr = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_r.mem_rd   <= MEM_RD_RST;
      lat_r.mem_wr   <= MEM_WR_RST;
      lat_r.cache_rd <= CACHE_RD_RST;
      lat_r.cache_wr <= CACHE_WR_RST;
    end else begin
      lat_r <= lat_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/dmwc_ctrl.sv
// ----------------------------------------------------------------------------
// dmwc_ctrl
// Cache controller: tag lookup, write-back and fill sequencing, word access,
// time accounting and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmwc_ctrl
  import dmwc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Item channel
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [OP_W-1:0]      in_op,
  input  wire logic [ADDR_W-1:0]    in_addr,
  input  wire logic [DATA_W-1:0]    in_wdata,
  // Result channel
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [DATA_W-1:0]         out_rdata,
  output logic                      out_hit,
  output logic                      out_wb,
  output logic [TIME_W-1:0]         out_time,
  // Latencies
  input  wire lat_t                 lat,
  // Memories
  output tag_req_t                  tag_req,
  input  wire logic [TAG_RAM_W-1:0] tag_q,
  output cache_req_t                cache_req,
  input  wire logic [DATA_W-1:0]    cache_q,
  output mem_req_t                  mem_req,
  input  wire logic [DATA_W-1:0]    mem_q
);

  localparam logic [BEAT_W-1:0] BEAT_END = BEAT_W'(WORDS_PER_LINE);

  state_t state_r, state_nxt;

  logic [OP_W-1:0]   op_r, op_nxt;
  logic [TAG_W-1:0]  tag_r, tag_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [DATA_W-1:0] wdata_r, wdata_nxt;
  logic [TAG_W-1:0]  old_tag_r, old_tag_nxt;
  logic              hit_r, hit_nxt;
  logic              wb_r, wb_nxt;
  logic [BEAT_W-1:0] beat_r, beat_nxt;
  logic              pend_r, pend_nxt;
  logic [OFF_W-1:0]  pend_off_r, pend_off_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [LINES-1:0]  valid_r, valid_nxt;
  logic [MEM_AW-1:0] clr_cnt_r, clr_cnt_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_rdata_r, out_rdata_nxt;
  logic              out_hit_r, out_hit_nxt;
  logic              out_wb_r, out_wb_nxt;
  logic [TIME_W-1:0] out_time_r, out_time_nxt;

  logic              in_xfer;
  logic              lookup_hit;
  logic              victim_dirty;
  logic              beat_end;
  logic              clr_end;
  logic              out_free;
  logic [TIME_W-1:0] time_fin;

  assign in_xfer      = in_valid && in_ready;
  assign lookup_hit   = valid_r[idx_r] && (tag_q[TAG_W-1:0] == tag_r);
  assign victim_dirty = valid_r[idx_r] && tag_q[TAG_W];
  assign beat_end     = (beat_r == BEAT_END);
  assign clr_end      = (clr_cnt_r == {MEM_AW{1'b1}});
  assign out_free     = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_rdata = out_rdata_r;
  assign out_hit   = out_hit_r;
  assign out_wb    = out_wb_r;
  assign out_time  = out_time_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_end) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = (in_op == OP_READ || in_op == OP_WRITE) ? ST_LOOKUP : ST_FINISH;
        end
      end
      ST_LOOKUP: begin
        if (lookup_hit) begin
          state_nxt = ST_ACCESS;
        end else if (victim_dirty) begin
          state_nxt = ST_WBACK;
        end else begin
          state_nxt = ST_FILL;
        end
      end
      ST_WBACK: begin
        if (beat_end) state_nxt = ST_FILL;
      end
      ST_FILL: begin
        if (beat_end) state_nxt = ST_ACCESS;
      end
      ST_ACCESS: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Memory requests and handshake outputs
  always_comb begin
    in_ready  = 1'b0;
    tag_req   = '0;
    cache_req = '0;
    mem_req   = '0;

    tag_req.raddr = in_addr[2 + OFF_W +: IDX_W];
    tag_req.waddr = idx_r;
    tag_req.wdata = {1'b0, tag_r};

    unique case (state_r)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_cnt_r;
      end
      ST_IDLE: begin
        in_ready   = 1'b1;
        tag_req.re = in_valid;
      end
      ST_LOOKUP: begin
        tag_req.we = !lookup_hit;
      end
      ST_WBACK: begin
        cache_req.re    = !beat_end;
        cache_req.raddr = {idx_r, beat_r[OFF_W-1:0]};
        mem_req.we      = pend_r;
        mem_req.waddr   = mem_addr(old_tag_r, idx_r, pend_off_r);
        mem_req.wdata   = cache_q;
      end
      ST_FILL: begin
        mem_req.re      = !beat_end;
        mem_req.raddr   = mem_addr(tag_r, idx_r, beat_r[OFF_W-1:0]);
        cache_req.we    = pend_r;
        cache_req.waddr = {idx_r, pend_off_r};
        cache_req.wdata = mem_q;
      end
      ST_ACCESS: begin
        cache_req.re    = (op_r == OP_READ);
        cache_req.raddr = {idx_r, off_r};
        cache_req.we    = (op_r == OP_WRITE);
        cache_req.waddr = {idx_r, off_r};
        cache_req.wdata = wdata_r;
        // Mark the line dirty on a word write
        tag_req.we      = (op_r == OP_WRITE);
        tag_req.wdata   = {1'b1, tag_r};
      end
      ST_FINISH: ;
      default: ;
    endcase
  end

  // Closing time charge of an item
  always_comb begin
    case (op_r)
      OP_READ:  time_fin = time_r + TIME_W'(lat.cache_rd);
      OP_WRITE: time_fin = time_r + TIME_W'(lat.cache_wr);
      OP_CLEAR: time_fin = '0;
      default:  time_fin = time_r;
    endcase
  end

  // Datapath next values
  always_comb begin
    op_nxt        = op_r;
    tag_nxt       = tag_r;
    idx_nxt       = idx_r;
    off_nxt       = off_r;
    wdata_nxt     = wdata_r;
    old_tag_nxt   = old_tag_r;
    hit_nxt       = hit_r;
    wb_nxt        = wb_r;
    beat_nxt      = beat_r;
    pend_nxt      = pend_r;
    pend_off_nxt  = pend_off_r;
    time_nxt      = time_r;
    valid_nxt     = valid_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_rdata_nxt = out_rdata_r;
    out_hit_nxt   = out_hit_r;
    out_wb_nxt    = out_wb_r;
    out_time_nxt  = out_time_r;

    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
      ST_IDLE: begin
        if (in_xfer) begin
          op_nxt    = in_op;
          off_nxt   = in_addr[2 +: OFF_W];
          idx_nxt   = in_addr[2 + OFF_W +: IDX_W];
          tag_nxt   = in_addr[2 + OFF_W + IDX_W +: TAG_W];
          wdata_nxt = in_wdata;
          hit_nxt   = 1'b0;
          wb_nxt    = 1'b0;
        end
      end
      ST_LOOKUP: begin
        hit_nxt     = lookup_hit;
        old_tag_nxt = tag_q[TAG_W-1:0];
        beat_nxt    = '0;
        pend_nxt    = 1'b0;
        // Miss: charge the fetch and claim the line for the new tag
        if (!lookup_hit) begin
          time_nxt         = time_r + TIME_W'(lat.mem_rd);
          wb_nxt           = victim_dirty;
          valid_nxt[idx_r] = 1'b1;
        end
      end
      ST_WBACK, ST_FILL: begin
        // Advance the line beat; the move lands in the cycle after its read
        beat_nxt     = beat_end ? '0 : beat_r + 1'b1;
        pend_nxt     = !beat_end;
        pend_off_nxt = beat_r[OFF_W-1:0];
        if (state_r == ST_WBACK && beat_end) begin
          time_nxt = time_r + TIME_W'(lat.mem_wr);
        end
      end
      ST_ACCESS: ;
      ST_FINISH: begin
        // Load the result once the output register is free
        if (out_free) begin
          time_nxt      = time_fin;
          out_valid_nxt = 1'b1;
          out_rdata_nxt = (op_r == OP_READ) ? cache_q : '0;
          out_hit_nxt   = hit_r;
          out_wb_nxt    = wb_r;
          out_time_nxt  = time_fin;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      valid_r     <= '0;
      time_r      <= '0;
      beat_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      valid_r     <= valid_nxt;
      time_r      <= time_nxt;
      beat_r      <= beat_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    tag_r       <= tag_nxt;
    idx_r       <= idx_nxt;
    off_r       <= off_nxt;
    wdata_r     <= wdata_nxt;
    old_tag_r   <= old_tag_nxt;
    hit_r       <= hit_nxt;
    wb_r        <= wb_nxt;
    pend_off_r  <= pend_off_nxt;
    out_rdata_r <= out_rdata_nxt;
    out_hit_r   <= out_hit_nxt;
    out_wb_r    <= out_wb_nxt;
    out_time_r  <= out_time_nxt;
  end

`ifndef SYNTH
  // A line is valid whenever its word is accessed
  a_access_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ACCESS |-> valid_r[idx_r])
    else $error("word access to a line that is not valid");

  // A miss always moves on to a write-back or a fill
  a_miss_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOKUP && !lookup_hit) |=> (state_r == ST_WBACK || state_r == ST_FILL))
    else $error("miss did not start a line transfer");

  // A result appears only out of the finish step
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result loaded outside the finish step");

  // A write-back belongs to a miss
  a_wb_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && wb_r) |-> !hit_r)
    else $error("write-back reported on a hit");
`endif

endmodule

`default_nettype wire

### rtl/core/direct_mapped_writeback_cache.sv
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache
// Direct-mapped write-back, write-allocate cache over a word backing memory,
// with a running access-time total built from programmable latencies.
// ----------------------------------------------------------------------------
// Item transfer to result: lookup, then on a miss the line moves (write-back of a
// dirty victim, then fill, one word a cycle through a single memory port), then
// word access and finish; a counter clear or unused opcode goes straight to finish.
// One item is in flight; the next is taken the cycle after its result is
// registered, while that result may still wait.
// After reset the backing memory is cleared word by word, in_tready low.
`timescale 1ns / 1ps
`default_nettype none

module direct_mapped_writeback_cache
  import dmwc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Items: opcode[1:0], address[17:2], write_data[49:18], zero above
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // Results: read_data[31:0], hit[32], wrote_back[33], elapsed_time[65:34],
  // zero above
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // Configuration writes
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [LAT_W-1:0]       cfg_data
);

  lat_t                 lat;
  tag_req_t             tag_req;
  cache_req_t           cache_req;
  mem_req_t             mem_req;
  logic [TAG_RAM_W-1:0] tag_q;
  logic [DATA_W-1:0]    cache_q;
  logic [DATA_W-1:0]    mem_q;

  logic [DATA_W-1:0] out_rdata;
  logic              out_hit;
  logic              out_wb;
  logic [TIME_W-1:0] out_time;

  // Pack the result fields
  assign out_tdata = {{OUT_PAD_W{1'b0}}, out_time, out_wb, out_hit, out_rdata};

  dmwc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .lat       (lat)
  );

  dmwc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tdata[OP_W-1:0]),
    .in_addr   (in_tdata[OP_W +: ADDR_W]),
    .in_wdata  (in_tdata[OP_W + ADDR_W +: DATA_W]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_rdata (out_rdata),
    .out_hit   (out_hit),
    .out_wb    (out_wb),
    .out_time  (out_time),
    .lat       (lat),
    .tag_req   (tag_req),
    .tag_q     (tag_q),
    .cache_req (cache_req),
    .cache_q   (cache_q),
    .mem_req   (mem_req),
    .mem_q     (mem_q)
  );

  // Line tags with their dirty bits
  dmwc_ram #(
    .WIDTH (TAG_RAM_W),
    .DEPTH (LINES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_req.we),
    .waddr (tag_req.waddr),
    .wdata (tag_req.wdata),
    .re    (tag_req.re),
    .raddr (tag_req.raddr),
    .rdata (tag_q)
  );

  // Cached words
  dmwc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CACHE_WORDS)
  ) u_data_ram (
    .clk   (clk),
    .we    (cache_req.we),
    .waddr (cache_req.waddr),
    .wdata (cache_req.wdata),
    .re    (cache_req.re),
    .raddr (cache_req.raddr),
    .rdata (cache_q)
  );

  // Backing memory
  dmwc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEM_WORDS)
  ) u_mem_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_q)
  );

endmodule

`default_nettype wire
